// ===== sv/itoa_pkg.sv =====
package itoa_pkg;

   localparam int VALUE_WIDTH_DEF = 64;
   localparam int IN_VALUE_W      = 64;
   localparam int MAX_CHARS       = 64;
   localparam int DIGIT_W         = 6;
   localparam int CHAR_W          = 7;
   localparam int LEN_W           = 7;
   localparam int BASE_W          = 6;
   localparam int REQ_USER_W      = 1 + BASE_W;
   localparam int RSP_DATA_W      = 16;

   localparam logic [BASE_W-1:0]  BASE_MIN   = 6'd2;
   localparam logic [BASE_W-1:0]  BASE_MAX   = 6'd36;
   localparam logic [DIGIT_W-1:0] DEC_TEN    = 6'd10;
   localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0]  CHAR_A     = 7'h41;
   localparam logic [CHAR_W-1:0]  CHAR_MINUS = 7'h2D;

   typedef struct packed {
      logic load;       // take a new number
      logic div_step;   // one quotient bit
      logic store;      // write remainder digit, start next division
      logic emit_sign;  // put '-' into the output register
      logic rd_issue;   // read the next digit from the buffer
      logic load_out;   // put the read digit into the output register
   } cmd_type;

   typedef struct packed {
      logic bit_last;   // last quotient bit of this division
      logic quot_zero;  // quotient after the division is zero
      logic neg;        // number is negative
      logic out_free;   // output register can take a beat now
      logic rd_last;    // digit being emitted is the least significant
   } sts_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
      if (d < DEC_TEN) begin
         return CHAR_ZERO + CHAR_W'(d);
      end
      return CHAR_A + CHAR_W'(d - DEC_TEN);
   endfunction

endpackage

// ===== sv/itoa_ram.sv =====
module itoa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/itoa_ctrl.sv =====
module itoa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  itoa_pkg::sts_type sts,
   output itoa_pkg::cmd_type cmd
);
   import itoa_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DIVIDE = 3'd1;
   localparam logic [2:0] ST_STORE  = 3'd2;
   localparam logic [2:0] ST_SIGN   = 3'd3;
   localparam logic [2:0] ST_READ   = 3'd4;
   localparam logic [2:0] ST_LOAD   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (sts.bit_last) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            if (!sts.quot_zero) begin
               state_in = ST_DIVIDE;
            end else if (sts.neg) begin
               state_in = ST_SIGN;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_SIGN: begin
            if (sts.out_free) begin
               cmd.emit_sign = 1'b1;
               state_in      = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_LOAD;
         end
         ST_LOAD: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = sts.rd_last ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign in_ready = (state_ff == ST_IDLE);

endmodule

// ===== sv/itoa_dp.sv =====
module itoa_dp #(
   parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [itoa_pkg::IN_VALUE_W-1:0] in_value,
   input  logic                            in_signed_mode,
   input  logic [itoa_pkg::BASE_W-1:0]     in_base,
   input  itoa_pkg::cmd_type               cmd,
   output itoa_pkg::sts_type               sts,
   input  logic                            out_ready,
   output logic                            out_valid,
   output logic [itoa_pkg::CHAR_W-1:0]     out_character,
   output logic                            out_is_last,
   output logic [itoa_pkg::LEN_W-1:0]      out_length
);
   import itoa_pkg::*;

   localparam int SIGN_W = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
   localparam int CNT_W  = $clog2(VALUE_WIDTH);
   localparam int ADDR_W = $clog2(MAX_CHARS);

   logic [VALUE_WIDTH-1:0] dividend_ff, dividend_in;
   logic [DIGIT_W-1:0]     rem_ff, rem_in;
   logic [BASE_W-1:0]      base_ff, base_in;
   logic                   neg_ff, neg_in;
   logic [CNT_W-1:0]       bit_cnt_ff, bit_cnt_in;
   logic [LEN_W-1:0]       ndig_ff, ndig_in;
   logic [ADDR_W-1:0]      rd_ptr_ff, rd_ptr_in;

   logic                   out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]      char_ff, char_in;
   logic                   last_ff, last_in;
   logic [LEN_W-1:0]       len_ff, len_in;

   logic [SIGN_W-1:0]      sval;
   logic                   sneg;
   logic [SIGN_W-1:0]      smag;
   logic [DIGIT_W:0]       trial;
   logic                   ge;
   logic [DIGIT_W-1:0]     rd_digit;
   logic                   out_free;

   // input conditioning: sign handling and base clamp
   assign sval = in_value[SIGN_W-1:0];
   assign sneg = in_signed_mode & sval[SIGN_W-1];
   assign smag = sneg ? (~sval + 1'b1) : sval;

   // restoring division step, remainder stays below the base
   assign trial = {rem_ff, dividend_ff[VALUE_WIDTH-1]};
   assign ge    = (trial >= {1'b0, base_ff});

   assign out_free = !out_valid_ff || out_ready;

   always_comb begin
      dividend_in = dividend_ff;
      rem_in      = rem_ff;
      base_in     = base_ff;
      neg_in      = neg_ff;
      bit_cnt_in  = bit_cnt_ff;
      ndig_in     = ndig_ff;
      rd_ptr_in   = rd_ptr_ff;

      if (cmd.load) begin
         dividend_in = in_signed_mode ? VALUE_WIDTH'(smag) : in_value[VALUE_WIDTH-1:0];
         rem_in      = '0;
         neg_in      = sneg;
         bit_cnt_in  = '0;
         ndig_in     = '0;
         if (in_base < BASE_MIN) begin
            base_in = BASE_MIN;
         end else if (in_base > BASE_MAX) begin
            base_in = BASE_MAX;
         end else begin
            base_in = in_base;
         end
      end
      if (cmd.div_step) begin
         dividend_in = {dividend_ff[VALUE_WIDTH-2:0], ge};
         rem_in      = ge ? DIGIT_W'(trial - {1'b0, base_ff}) : trial[DIGIT_W-1:0];
         bit_cnt_in  = bit_cnt_ff + 1'b1;
      end
      if (cmd.store) begin
         rem_in     = '0;
         bit_cnt_in = '0;
         ndig_in    = ndig_ff + 1'b1;
         rd_ptr_in  = ndig_ff[ADDR_W-1:0];
      end
      if (cmd.load_out) begin
         rd_ptr_in = rd_ptr_ff - 1'b1;
      end
   end

   itoa_ram #(
      .WIDTH (DIGIT_W),
      .DEPTH (MAX_CHARS)
   ) u_digits (
      .clock   (clock),
      .wr_en   (cmd.store),
      .wr_addr (ndig_ff[ADDR_W-1:0]),
      .wr_data (rem_ff),
      .rd_en   (cmd.rd_issue),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_digit)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      len_in       = len_ff;
      if (out_ready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.emit_sign) begin
         out_valid_in = 1'b1;
         char_in      = CHAR_MINUS;
         last_in      = 1'b0;
         len_in       = ndig_ff + LEN_W'(neg_ff);
      end
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
         char_in      = digit_char(rd_digit);
         last_in      = (rd_ptr_ff == '0);
         len_in       = ndig_ff + LEN_W'(neg_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      base_ff     <= base_in;
      neg_ff      <= neg_in;
      bit_cnt_ff  <= bit_cnt_in;
      ndig_ff     <= ndig_in;
      rd_ptr_ff   <= rd_ptr_in;
      char_ff     <= char_in;
      last_ff     <= last_in;
      len_ff      <= len_in;
   end

   assign sts.bit_last  = (bit_cnt_ff == CNT_W'(VALUE_WIDTH - 1));
   assign sts.quot_zero = (dividend_ff == '0);
   assign sts.neg       = neg_ff;
   assign sts.out_free  = out_free;
   assign sts.rd_last   = (rd_ptr_ff == '0);

   assign out_valid     = out_valid_ff;
   assign out_character = char_ff;
   assign out_is_last   = last_ff;
   assign out_length    = len_ff;

endmodule

// ===== sv/integer_to_ascii_radix.sv =====
// Integer to ASCII conversion in any radix from 2 to 36.
// Input channel (req_): one beat per number. req_tdata carries the value,
// req_tuser carries the signed-mode flag and the base. In signed mode the low
// bits (up to 32) are a two's complement int and a negative number is
// printed as '-' followed by its magnitude; bases outside 2..36 are clamped.
// Output channel (rsp_): one beat per character, most significant digit
// first, uppercase letters above nine, rsp_tlast on the final character and
// the total character count on every beat.
// Throughput: one number at a time. A bit-serial divider produces one
// quotient bit per cycle; each digit is divided, then stored in the digit
// buffer, and once the quotient is zero the digits are read back out most
// significant first, each through the output register, with the sign first
// if negative. The next number is accepted only after the last beat is loaded.
// req_tready is high only while the block is idle.
// Reset clears the controller and drops rsp_tvalid; no buffer clearing is
// needed. When the receiver stalls, the current beat holds in the output
// register and the digit readout waits.
module integer_to_ascii_radix #(
   parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [itoa_pkg::IN_VALUE_W-1:0] req_tdata,  // [63:0] value
   input  logic [itoa_pkg::REQ_USER_W-1:0] req_tuser,  // [0] signed_mode, [6:1] base
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [itoa_pkg::RSP_DATA_W-1:0] rsp_tdata,  // [6:0] character, [13:7] length
   output logic                            rsp_tlast   // is_last
);
   import itoa_pkg::*;

   cmd_type           cmd;
   sts_type           sts;
   logic [CHAR_W-1:0] rsp_char;
   logic [LEN_W-1:0]  rsp_len;

   itoa_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .sts      (sts),
      .cmd      (cmd)
   );

   itoa_dp #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .in_value       (req_tdata),
      .in_signed_mode (req_tuser[0]),
      .in_base        (req_tuser[BASE_W:1]),
      .cmd            (cmd),
      .sts            (sts),
      .out_ready      (rsp_tready),
      .out_valid      (rsp_tvalid),
      .out_character  (rsp_char),
      .out_is_last    (rsp_tlast),
      .out_length     (rsp_len)
   );

   assign rsp_tdata = {{(RSP_DATA_W - CHAR_W - LEN_W){1'b0}}, rsp_len, rsp_char};

   // busy after an accept until the last character is loaded into the output register
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted while a number is in progress");

   // the sign never ends a number
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_char == CHAR_MINUS) |-> !rsp_tlast)
      else $error("sign marked as last character");

   a_length_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_len != '0) && (rsp_len <= LEN_W'(MAX_CHARS)))
      else $error("character count out of range");

endmodule

// ===== verif/tb_integer_to_ascii_radix.sv =====
module tb_integer_to_ascii_radix;
   timeunit 1ns;
   timeprecision 1ps;

   import itoa_pkg::*;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
      logic [LEN_W-1:0]  len;
   } char_beat_type;

   // txt holds the expected printout when it is obvious, zero means use the predictor
   typedef struct packed {
      logic [63:0]       value;
      logic              smode;
      logic [BASE_W-1:0] base;
      logic [8*20-1:0]   txt;
   } number_row_type;

   localparam int NUM_ROWS = 23;
   localparam int RANDOM_NUMBERS = 400;

   localparam number_row_type NUMBER_ROWS [NUM_ROWS] = '{
      '{64'd0,                  1'b0, 6'd10, "0"},
      '{64'd0,                  1'b1, 6'd10, "0"},
      '{64'hFFFFFFFFFFFFFFFF,   1'b0, 6'd16, "FFFFFFFFFFFFFFFF"},
      '{64'hFFFFFFFFFFFFFFFF,   1'b0, 6'd10, "18446744073709551615"},
      '{64'hFFFFFFFFFFFFFFFF,   1'b0, 6'd2,  160'd0},
      '{64'h0000000080000000,   1'b1, 6'd10, "-2147483648"},
      '{64'hFFFFFFFF80000000,   1'b1, 6'd2,  160'd0},
      '{64'h0000000080000000,   1'b1, 6'd36, 160'd0},
      '{64'h00000000FFFFFFFF,   1'b1, 6'd10, "-1"},
      '{64'hFFFFFFFFFFFFFFFF,   1'b1, 6'd2,  "-1"},
      '{64'h000000007FFFFFFF,   1'b1, 6'd10, "2147483647"},
      '{64'hDEADBEEF00000005,   1'b1, 6'd10, "5"},
      '{64'h0000000080000000,   1'b0, 6'd10, "2147483648"},
      '{64'd35,                 1'b0, 6'd36, "Z"},
      '{64'd255,                1'b0, 6'd16, "FF"},
      '{64'd10,                 1'b0, 6'd11, "A"},
      '{64'd9,                  1'b0, 6'd10, "9"},
      '{64'd1,                  1'b0, 6'd2,  "1"},
      '{64'd5,                  1'b0, 6'd0,  "101"},
      '{64'd5,                  1'b0, 6'd1,  "101"},
      '{64'd35,                 1'b0, 6'd37, "Z"},
      '{64'd36,                 1'b0, 6'd63, "10"},
      '{64'h8000000000000000,   1'b0, 6'd36, 160'd0}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [IN_VALUE_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;   // [0] signed_mode, [6:1] base
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // [6:0] character, [13:7] length
   logic                  rsp_tlast;

   char_beat_type expected_chars[$];
   char_beat_type got_beat;
   char_beat_type want_beat;
   int            mismatch_cnt = 0;
   int            tx_idle_pct = 27;
   int            rx_idle_pct = 83;

   integer_to_ascii_radix dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatch_cnt++;
   endtask

   // digits of the magnitude are collected least significant first
   task automatic predict_chars(input logic [63:0] value, input logic smode,
                                input logic [BASE_W-1:0] base_in);
      logic [63:0]        mag;
      logic [63:0]        radix;
      logic [DIGIT_W-1:0] digs [MAX_CHARS];
      logic [DIGIT_W-1:0] d;
      logic               neg;
      int                 n;
      int                 total;
      char_beat_type      b;
      radix = (base_in < BASE_MIN) ? 64'(BASE_MIN) :
              (base_in > BASE_MAX) ? 64'(BASE_MAX) : 64'(base_in);
      neg = 1'b0;
      mag = value;
      if (smode) begin
         mag = {32'd0, value[31:0]};
         if (value[31]) begin
            neg = 1'b1;
            mag = {32'd0, ~value[31:0] + 32'd1};
         end
      end
      n = 0;
      do begin
         digs[n] = DIGIT_W'(mag % radix);
         mag = mag / radix;
         n++;
      end while (mag != 0);
      total = n + (neg ? 1 : 0);
      b.len = LEN_W'(total);
      if (neg) begin
         b.ch = CHAR_MINUS;
         b.last = (total == 1);
         expected_chars.push_back(b);
      end
      for (int k = n - 1; k >= 0; k--) begin
         d = digs[k];
         b.ch = (d < DEC_TEN) ? CHAR_ZERO + CHAR_W'(d) : CHAR_A + CHAR_W'(d - DEC_TEN);
         b.last = (k == 0);
         expected_chars.push_back(b);
      end
   endtask

   task automatic queue_text(input logic [8*20-1:0] txt);
      int            n;
      char_beat_type b;
      n = 0;
      for (int i = 0; i < 20; i++) begin
         if (txt[8*i +: 8] != 8'd0) n = i + 1;
      end
      for (int i = n - 1; i >= 0; i--) begin
         b.ch = txt[8*i +: CHAR_W];
         b.last = (i == 0);
         b.len = LEN_W'(n);
         expected_chars.push_back(b);
      end
   endtask

   task automatic send_number(input logic [63:0] value, input logic smode,
                              input logic [BASE_W-1:0] base_in, input logic [8*20-1:0] txt);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= {base_in, smode};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (txt != '0) queue_text(txt);
      else predict_chars(value, smode, base_in);
   endtask

   task automatic drain_numbers();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_chars.size() != 0);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_beat.ch   = rsp_tdata[CHAR_W-1:0];
         got_beat.len  = rsp_tdata[CHAR_W +: LEN_W];
         got_beat.last = rsp_tlast;
         if (expected_chars.size() == 0) begin
            report_mismatch($sformatf("character 0x%02h with nothing expected", got_beat.ch));
         end else begin
            want_beat = expected_chars.pop_front();
            if (got_beat.ch != want_beat.ch)
               report_mismatch($sformatf("character 0x%02h, want 0x%02h",
                                         got_beat.ch, want_beat.ch));
            if (got_beat.last != want_beat.last)
               report_mismatch($sformatf("tlast %0b, want %0b", got_beat.last, want_beat.last));
            if (got_beat.len != want_beat.len)
               report_mismatch($sformatf("length %0d, want %0d", got_beat.len, want_beat.len));
         end
      end
      rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
   end

   initial begin
      logic [63:0]       value;
      logic              smode;
      logic [BASE_W-1:0] base_in;
      int                nb;
      int                sel;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_ROWS; i++) begin
         send_number(NUMBER_ROWS[i].value, NUMBER_ROWS[i].smode, NUMBER_ROWS[i].base,
                     NUMBER_ROWS[i].txt);
      end

      for (int i = 0; i < RANDOM_NUMBERS; i++) begin
         if (i == RANDOM_NUMBERS / 3) begin
            drain_numbers();
            tx_idle_pct = 83;
            rx_idle_pct = 27;
         end else if (i == 2 * RANDOM_NUMBERS / 3) begin
            drain_numbers();
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         // random magnitude width spreads the numbers over short and long lengths
         nb = $urandom_range(64, 1);
         value = {$urandom, $urandom};
         if (nb < 64) value &= (64'd1 << nb) - 64'd1;
         smode = 1'($urandom_range(1, 0));
         if (smode) begin
            value[63:32] = $urandom;
            if ($urandom_range(1, 0) == 1) value[31:0] = ~value[31:0];
         end
         sel = $urandom_range(99, 0);
         if (sel < 2) value = 64'd0;
         else if (sel < 4) value = 64'hFFFFFFFFFFFFFFFF;
         else if (sel < 6) value = {$urandom, 32'h80000000};
         if ($urandom_range(9, 0) == 0) base_in = BASE_W'($urandom_range(63, 0));
         else base_in = BASE_W'($urandom_range(36, 2));
         send_number(value, smode, base_in, '0);
      end
      req_tvalid <= 1'b0;

      while (expected_chars.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatch_cnt == 0 && expected_chars.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #200_000_000;
      $display("timeout with %0d characters outstanding", expected_chars.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
